// ----- src/ugs_pkg.sv -----
package ugs_pkg;

    // Glyph width kept after decoding, and the width of one histogram counter.
    localparam int GLYPH_BITS    = 16;
    localparam int COUNT_BITS    = 24;
    localparam int STORE_DEPTH   = 1 << GLYPH_BITS;

    // Fixed widths of the register and the result fields.
    localparam int THRESH_BITS   = 16;
    localparam int STRING_BITS   = 16;
    localparam int DISTINCT_BITS = 17;
    localparam int LARGEST_BITS  = 16;
    localparam int TOTAL_BITS    = 32;
    localparam int LEN_BITS      = 3;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET  = THRESH_BITS'(126);
    localparam logic [LEN_BITS-1:0]    LONGEST_RESET = LEN_BITS'(1);
    localparam logic [LEN_BITS-1:0]    LEN_SINGLE    = LEN_BITS'(1);

    // Glyph that has finished decoding and must be counted in the histogram.
    typedef struct packed {
        logic                  valid;
        logic [GLYPH_BITS-1:0] glyph;
    } t_hist_req;

    // Statistics captured by the decoder when a string terminator arrives.
    typedef struct packed {
        logic                    valid;
        logic [STRING_BITS-1:0]  string_glyphs;
        logic [LARGEST_BITS-1:0] largest_glyph;
        logic [TOTAL_BITS-1:0]   total_glyphs;
        logic [LEN_BITS-1:0]     longest_sequence;
        logic                    ended_early;
    } t_snap;

    // One complete result transaction.
    typedef struct packed {
        logic [STRING_BITS-1:0]   string_glyphs;
        logic [DISTINCT_BITS-1:0] distinct_glyphs;
        logic [LARGEST_BITS-1:0]  largest_glyph;
        logic [TOTAL_BITS-1:0]    total_glyphs;
        logic [LEN_BITS-1:0]      longest_sequence;
        logic                     ended_early;
    } t_result;

    typedef struct packed {
        logic [LEN_BITS-1:0]   len;
        logic [GLYPH_BITS-1:0] acc;
    } t_lead;

    // Classify a lead byte: sequence length and its payload bits.
    // Bytes 0x80 to 0xBF are stray continuation bytes and give the zero glyph.
    function automatic t_lead lead_decode(input logic [7:0] b);
        t_lead r;
        if ((b & 8'hFC) == 8'hFC) begin
            r.len = LEN_BITS'(6);
            r.acc = GLYPH_BITS'(b & 8'h01);
        end else if ((b & 8'hF8) == 8'hF8) begin
            r.len = LEN_BITS'(5);
            r.acc = GLYPH_BITS'(b & 8'h03);
        end else if ((b & 8'hF0) == 8'hF0) begin
            r.len = LEN_BITS'(4);
            r.acc = GLYPH_BITS'(b & 8'h07);
        end else if ((b & 8'hE0) == 8'hE0) begin
            r.len = LEN_BITS'(3);
            r.acc = GLYPH_BITS'(b & 8'h0F);
        end else if ((b & 8'hC0) == 8'hC0) begin
            r.len = LEN_BITS'(2);
            r.acc = GLYPH_BITS'(b & 8'h1F);
        end else begin
            r.len = LEN_SINGLE;
            r.acc = b[7] ? '0 : GLYPH_BITS'(b);
        end
        return r;
    endfunction

endpackage

// ----- src/ugs_decoder.sv -----
module ugs_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ugs_pkg::THRESH_BITS-1:0]     i_cfg_wdata,
    input  logic                                i_accept,
    input  logic [7:0]                          i_text_byte,
    output ugs_pkg::t_hist_req                  o_hist_req,
    output ugs_pkg::t_snap                      o_snap
);

    logic [ugs_pkg::THRESH_BITS-1:0]  r_threshold;
    logic [ugs_pkg::LEN_BITS-1:0]     r_rem, n_rem;
    logic [ugs_pkg::GLYPH_BITS-1:0]   r_acc, n_acc;
    logic [ugs_pkg::STRING_BITS-1:0]  r_string, n_string;
    logic [ugs_pkg::GLYPH_BITS-1:0]   r_largest, n_largest;
    logic [ugs_pkg::TOTAL_BITS-1:0]   r_total, n_total;
    logic [ugs_pkg::LEN_BITS-1:0]     r_longest, n_longest;
    logic                             r_skip, n_skip;

    logic                             finish;
    logic [ugs_pkg::GLYPH_BITS-1:0]   fin_glyph;
    logic [ugs_pkg::GLYPH_BITS-1:0]   acc_shift;
    ugs_pkg::t_lead                   lead;

    always_comb begin
        n_rem     = r_rem;
        n_acc     = r_acc;
        n_string  = r_string;
        n_largest = r_largest;
        n_total   = r_total;
        n_longest = r_longest;
        n_skip    = r_skip;
        finish    = 1'b0;
        fin_glyph = '0;
        acc_shift = ugs_pkg::GLYPH_BITS'({r_acc, i_text_byte[5:0]});
        lead      = ugs_pkg::lead_decode(i_text_byte);

        o_hist_req = '0;

        o_snap.valid            = 1'b0;
        o_snap.string_glyphs    = r_string;
        o_snap.largest_glyph    = ugs_pkg::LARGEST_BITS'(r_largest);
        o_snap.total_glyphs     = r_total;
        o_snap.longest_sequence = r_longest;
        o_snap.ended_early      = r_skip || (r_rem != '0);

        if (i_accept) begin
            if (i_text_byte == 8'h00) begin
                o_snap.valid = 1'b1;
                n_string     = '0;
                n_skip       = 1'b0;
                n_rem        = '0;
                n_acc        = '0;
            end else if (!r_skip) begin
                if (r_rem != '0) begin
                    n_rem = r_rem - 1'b1;
                    if (r_rem == ugs_pkg::LEN_SINGLE) begin
                        finish    = 1'b1;
                        fin_glyph = acc_shift;
                        n_acc     = '0;
                    end else begin
                        n_acc = acc_shift;
                    end
                end else begin
                    if (lead.len > r_longest) begin
                        n_longest = lead.len;
                    end
                    if (lead.len == ugs_pkg::LEN_SINGLE) begin
                        finish    = 1'b1;
                        fin_glyph = lead.acc;
                        n_acc     = '0;
                    end else begin
                        n_rem = lead.len - 1'b1;
                        n_acc = lead.acc;
                    end
                end
            end
        end

        // A zero glyph ends the string early; the rest is skipped.
        if (finish) begin
            if (fin_glyph == '0) begin
                n_skip = 1'b1;
            end else begin
                o_hist_req.valid = ugs_pkg::THRESH_BITS'(fin_glyph) > r_threshold;
                o_hist_req.glyph = fin_glyph;
                if (fin_glyph > r_largest) begin
                    n_largest = fin_glyph;
                end
                if (r_total != '1) begin
                    n_total = r_total + 1'b1;
                end
                if (r_string != '1) begin
                    n_string = r_string + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ugs_pkg::THRESH_RESET;
            r_rem       <= '0;
            r_acc       <= '0;
            r_string    <= '0;
            r_largest   <= '0;
            r_total     <= '0;
            r_longest   <= ugs_pkg::LONGEST_RESET;
            r_skip      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
            r_rem     <= n_rem;
            r_acc     <= n_acc;
            r_string  <= n_string;
            r_largest <= n_largest;
            r_total   <= n_total;
            r_longest <= n_longest;
            r_skip    <= n_skip;
        end
    end

    // A sequence never has more than five continuation bytes outstanding.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= ugs_pkg::LEN_BITS'(5))
        else $error("continuation count out of range");

    // Skipping only starts through a zero glyph, which never reaches the histogram.
    a_skip_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_skip && !r_skip) |-> !o_hist_req.valid)
        else $error("histogram request issued for a zero glyph");

    // While skipping, a non-zero byte changes nothing.
    a_skip_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip && i_accept && i_text_byte != 8'h00) |=> (r_skip && $stable(r_total)))
        else $error("decoder state moved while skipping");

endmodule

// ----- src/ugs_hist.sv -----
module ugs_hist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ugs_pkg::t_hist_req                  i_req,
    output logic [ugs_pkg::DISTINCT_BITS-1:0]   o_distinct,
    output logic                                o_busy
);

    logic [ugs_pkg::COUNT_BITS-1:0] r_mem [ugs_pkg::STORE_DEPTH];
    logic [ugs_pkg::COUNT_BITS-1:0] r_rd_data;

    logic                           r_s1_valid;
    logic [ugs_pkg::GLYPH_BITS-1:0] r_s1_glyph;

    logic                           r_fwd_valid;
    logic [ugs_pkg::GLYPH_BITS-1:0] r_fwd_addr;
    logic [ugs_pkg::COUNT_BITS-1:0] r_fwd_data;

    logic                           r_clr_busy;
    logic [ugs_pkg::GLYPH_BITS-1:0] r_clr_addr;

    logic [ugs_pkg::DISTINCT_BITS-1:0] r_distinct, n_distinct;

    logic [ugs_pkg::COUNT_BITS-1:0] cur_cnt;
    logic [ugs_pkg::COUNT_BITS-1:0] new_cnt;
    logic                           mem_we;
    logic [ugs_pkg::GLYPH_BITS-1:0] mem_waddr;
    logic [ugs_pkg::COUNT_BITS-1:0] mem_wdata;

    always_comb begin
        // The read issued alongside the previous write sees the old count.
        cur_cnt = (r_fwd_valid && (r_fwd_addr == r_s1_glyph)) ? r_fwd_data : r_rd_data;
        new_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;

        n_distinct = r_distinct;
        if (r_s1_valid && (cur_cnt == '0) && (r_distinct != '1)) begin
            n_distinct = r_distinct + 1'b1;
        end

        mem_we    = r_clr_busy || r_s1_valid;
        mem_waddr = r_clr_busy ? r_clr_addr : r_s1_glyph;
        mem_wdata = r_clr_busy ? '0 : new_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_rd_data <= r_mem[i_req.glyph];
        end
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_glyph <= i_req.glyph;
        r_fwd_addr <= r_s1_glyph;
        r_fwd_data <= new_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_distinct  <= '0;
        end else begin
            r_s1_valid  <= i_req.valid;
            r_fwd_valid <= r_s1_valid;
            r_distinct  <= n_distinct;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    assign o_distinct = r_distinct;
    assign o_busy     = r_clr_busy;

    // No glyph may be counted while the store is still being cleared.
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!i_req.valid && !r_s1_valid))
        else $error("histogram access during clearing pass");

    // The distinct count never goes down and grows by at most one.
    a_distinct_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_distinct == $past(r_distinct)) ||
                            (r_distinct == $past(r_distinct) + 1'b1)))
        else $error("distinct count stepped wrongly");

    // A new distinct glyph can only follow a counted glyph.
    a_distinct_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid) |=> $stable(r_distinct))
        else $error("distinct count moved without a glyph");

endmodule

// ----- src/utf8_glyph_statistics.sv -----
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_text_byte
// result    out        o_out_valid / i_out_stall  o_string_glyphs .. o_ended_early
// config    in         i_cfg_we                   i_cfg_wdata
//
// One byte is taken every cycle unless the input stalls; a result is registered in the result
// stage and then in the output register. The histogram read-modify-write (one memory read,
// one write a cycle) sets that rate. After reset the histogram is cleared, one entry a
// cycle, over all 65536 entries; no byte is taken during that pass, while configuration
// writes are taken as usual. Apart from that pass, input stalls only when both the output
// register and the result stage hold results and the output is stalled.
module utf8_glyph_statistics (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ugs_pkg::THRESH_BITS-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_text_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ugs_pkg::STRING_BITS-1:0]     o_string_glyphs,
    output logic [ugs_pkg::DISTINCT_BITS-1:0]   o_distinct_glyphs,
    output logic [ugs_pkg::LARGEST_BITS-1:0]    o_largest_glyph,
    output logic [ugs_pkg::TOTAL_BITS-1:0]      o_total_glyphs,
    output logic [ugs_pkg::LEN_BITS-1:0]        o_longest_sequence,
    output logic                                o_ended_early
);

    ugs_pkg::t_hist_req                 hist_req;
    ugs_pkg::t_snap                     snap;
    logic [ugs_pkg::DISTINCT_BITS-1:0]  distinct;
    logic                               busy;
    logic                               in_accept;
    logic                               out_free;
    logic                               res_hold;

    // Result stage: holds a terminator's statistics so that the
    // distinct count of the last glyph before it has been written back.
    logic                               r_res_valid;
    ugs_pkg::t_snap                     r_res;

    // Output register.
    logic                               r_out_valid;
    ugs_pkg::t_result                   r_out;

    ugs_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_accept),
        .i_text_byte (i_text_byte),
        .o_hist_req  (hist_req),
        .o_snap      (snap)
    );

    ugs_hist u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (hist_req),
        .o_distinct (distinct),
        .o_busy     (busy)
    );

    // The output register can take a new transaction when it is empty or
    // being emptied in this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign res_hold   = r_res_valid && !out_free;
    assign o_in_stall = busy || res_hold;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!res_hold) begin
            r_res <= snap;
        end
        if (r_res_valid && out_free) begin
            r_out.string_glyphs    <= r_res.string_glyphs;
            r_out.distinct_glyphs  <= distinct;
            r_out.largest_glyph    <= r_res.largest_glyph;
            r_out.total_glyphs     <= r_res.total_glyphs;
            r_out.longest_sequence <= r_res.longest_sequence;
            r_out.ended_early      <= r_res.ended_early;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!res_hold) begin
                r_res_valid <= snap.valid;
            end
            if (r_res_valid && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_string_glyphs    = r_out.string_glyphs;
    assign o_distinct_glyphs  = r_out.distinct_glyphs;
    assign o_largest_glyph    = r_out.largest_glyph;
    assign o_total_glyphs     = r_out.total_glyphs;
    assign o_longest_sequence = r_out.longest_sequence;
    assign o_ended_early      = r_out.ended_early;

    // Every accepted terminator lands in the result stage on the next cycle.
    a_term_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_text_byte == 8'h00) |=> r_res_valid)
        else $error("terminator lost before the result stage");

    // A held result stage blocks the input, so no terminator can overwrite it.
    a_res_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !out_free) |=> (r_res_valid && $stable(r_res)))
        else $error("pending result overwritten");

    // A stalled result transaction keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule
